// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// types, codes and helpers shared by the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int MAG_BITS     = OPERAND_BITS + 1;
    localparam int PROD_BITS    = 2 * OPERAND_BITS + 1;
    localparam int SUM_BITS     = PROD_BITS + 1;
    localparam int CNT_BITS     = $clog2(SUM_BITS + 1);
    localparam int NUM_OUT_BITS = 33;
    localparam int DEN_OUT_BITS = 31;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [2:0] {
        OP_REDUCE   = 3'd0,
        OP_MULTIPLY = 3'd1,
        OP_DIVIDE   = 3'd2,
        OP_ADD      = 3'd3,
        OP_SUBTRACT = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_EUCLID,
        BK_QUO_X,
        BK_QUO_Y,
        BK_MUL,
        BK_SUM,
        BK_DONE
    } back_state_t;

    // which fraction the shared reduction is working on
    typedef enum logic [1:0] {
        PS_FIRST,
        PS_SECOND,
        PS_RESULT
    } pass_t;

    typedef struct packed {
        logic [2:0]                      operation;
        logic signed [OPERAND_BITS-1:0]  first_numerator;
        logic signed [OPERAND_BITS-1:0]  first_denominator;
        logic signed [OPERAND_BITS-1:0]  second_numerator;
        logic signed [OPERAND_BITS-1:0]  second_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_OUT_BITS-1:0]  result_numerator;
        logic [DEN_OUT_BITS-1:0]         result_denominator;
        logic [1:0]                      status;
    } out_item_t;

    // classified work passed from the front to the back
    typedef struct packed {
        logic [2:0]          op;
        logic                is_reduce;
        logic [1:0]          status;
        logic                a_neg;
        logic [MAG_BITS-1:0] a_num;
        logic [MAG_BITS-1:0] a_den;
        logic                b_neg;
        logic [MAG_BITS-1:0] b_num;
        logic [MAG_BITS-1:0] b_den;
    } job_t;

    function automatic logic [MAG_BITS-1:0] mag_of(input logic [OPERAND_BITS-1:0] v);
        logic [MAG_BITS-1:0] x;
        x = {v[OPERAND_BITS-1], v};
        return v[OPERAND_BITS-1] ? (MAG_BITS'(0) - x) : x;
    endfunction

endpackage

// File: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// reduce, multiply, divide, add or subtract two signed fractions
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid, in_ready, in_data) takes an operation and two
//   fractions; out channel (out_valid, out_ready, out_data) returns one
//   reduced fraction and a status per transfer
//   a front stage checks for zero denominators and division by a zero
//   fraction and splits operands into sign and magnitude; a two-entry queue
//   feeds the back end, which runs euclid gcd and exact division on a shared
//   bit-serial divider (one quotient bit per cycle); each reduction runs
//   euclid steps, then a gcd check and the two exact divisions; a binary
//   operation runs three reductions
//   throughput: one item per back-end run, set by the serial divider
//   reset clears the queue and the back-end state; no item is in flight
//   when the receiver stalls the finished result is held in the output
//   register, the back end takes the next job and waits to hand it over,
//   and the front keeps filling the queue until it is full
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rau_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rau_pkg::out_item_t out_data
);
    import rau_pkg::*;

    logic job_valid, job_ready;
    job_t job_data;

    rau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job_data  (job_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: rtl/rau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front
// accepts items, checks errors and splits operands into sign and magnitude
// ----------------------------------------------------------------------------
module rau_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rau_pkg::in_item_t in_data,
    output logic             job_valid,
    input  logic             job_ready,
    output rau_pkg::job_t    job_data
);
    import rau_pkg::*;

    job_t                   q_reg [QUEUE_DEPTH];
    logic                   wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]             cnt_reg, cnt_next;
    job_t                   job_in;
    logic                   push, pop, red, d1z, d2z, n2z;

    always_comb
    begin
        red = !(in_data.operation inside {OP_MULTIPLY, OP_DIVIDE, OP_ADD, OP_SUBTRACT});
        d1z = in_data.first_denominator == '0;
        d2z = in_data.second_denominator == '0;
        n2z = in_data.second_numerator == '0;
        job_in.op        = in_data.operation;
        job_in.is_reduce = red;
        if (d1z || (!red && d2z))
            job_in.status = ST_ZERO_DEN;
        else if (in_data.operation == OP_DIVIDE && n2z)
            job_in.status = ST_DIV_ZERO;
        else
            job_in.status = ST_OK;
        job_in.a_neg = in_data.first_numerator[OPERAND_BITS-1]
                       ^ in_data.first_denominator[OPERAND_BITS-1];
        job_in.a_num = mag_of(in_data.first_numerator);
        job_in.a_den = mag_of(in_data.first_denominator);
        job_in.b_neg = in_data.second_numerator[OPERAND_BITS-1]
                       ^ in_data.second_denominator[OPERAND_BITS-1];
        job_in.b_num = mag_of(in_data.second_numerator);
        job_in.b_den = mag_of(in_data.second_denominator);
    end

    assign in_ready  = cnt_reg != 2'(QUEUE_DEPTH);
    assign job_valid = cnt_reg != 2'd0;
    assign job_data  = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job_in;
    end

endmodule

// File: rtl/rau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back
// reduces operands; for binary operations forms cross products and reduces the result
// ----------------------------------------------------------------------------
module rau_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_ready,
    input  rau_pkg::job_t     job_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rau_pkg::out_item_t out_data
);
    import rau_pkg::*;

    back_state_t          state_reg, state_next;
    pass_t                pass_reg;
    job_t                 job_reg;
    // working fraction and euclid pair
    logic [SUM_BITS-1:0]  x_reg, y_reg, ga_reg, gb_reg;
    // restoring divider, one quotient bit a cycle
    logic [SUM_BITS-1:0]  dvd_reg, dvs_reg, rem_reg, quo_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 div_start, div_done;
    logic [SUM_BITS-1:0]  div_dvd, div_dvs;
    logic [SUM_BITS:0]    trial;
    logic [SUM_BITS-1:0]  shifted;
    logic [MAG_BITS-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [SUM_BITS-1:0]  p1_reg, p2_reg;
    logic [SUM_BITS-1:0]  m_nn, m_dd, m_nd, m_dn;
    logic [SUM_BITS-1:0]  sum_mag;
    logic                 sum_neg, sb;
    logic                 rneg_reg;
    out_item_t            out_reg;
    logic                 out_valid_reg;

    function automatic logic [SUM_BITS-1:0] ext(input logic [MAG_BITS-1:0] v);
        return SUM_BITS'(v);
    endfunction

    assign shifted  = {rem_reg[SUM_BITS-2:0], dvd_reg[SUM_BITS-1]};
    assign trial    = {1'b0, shifted} - {1'b0, dvs_reg};
    assign div_done = cnt_reg == '0;

    assign m_nn = an_reg * bn_reg;
    assign m_dd = ad_reg * bd_reg;
    assign m_nd = an_reg * bd_reg;
    assign m_dn = ad_reg * bn_reg;

    assign job_ready = state_reg == BK_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        sb = job_reg.b_neg ^ (job_reg.op == OP_SUBTRACT);
        if (job_reg.a_neg == sb)
        begin
            sum_mag = p1_reg + p2_reg;
            sum_neg = sb;
        end
        else if (p1_reg >= p2_reg)
        begin
            sum_mag = p1_reg - p2_reg;
            sum_neg = job_reg.a_neg;
        end
        else
        begin
            sum_mag = p2_reg - p1_reg;
            sum_neg = sb;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (job_valid)
                    state_next = (job_data.status != ST_OK) ? BK_DONE : BK_GCD;
            BK_GCD:
                state_next = (gb_reg == '0) ? BK_QUO_X : BK_EUCLID;
            BK_EUCLID:
                if (div_done)
                    state_next = BK_GCD;
            BK_QUO_X:
                if (div_done)
                    state_next = BK_QUO_Y;
            BK_QUO_Y:
                if (div_done)
                begin
                    case (pass_reg)
                        PS_FIRST:  state_next = job_reg.is_reduce ? BK_DONE : BK_GCD;
                        PS_SECOND: state_next = BK_MUL;
                        default:   state_next = BK_DONE;
                    endcase
                end
            BK_MUL:
                state_next = BK_SUM;
            BK_SUM:
                state_next = BK_GCD;
            BK_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = ga_reg;
        div_dvs   = gb_reg;
        case (state_reg)
            BK_GCD:
            begin
                div_start = 1'b1;
                if (gb_reg == '0)
                begin
                    div_dvd = x_reg;
                    div_dvs = ga_reg;
                end
            end
            BK_QUO_X:
            begin
                div_start = div_done;
                div_dvd   = y_reg;
                div_dvs   = ga_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg <= '0;
            dvs_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (div_start)
        begin
            dvd_reg <= div_dvd;
            dvs_reg <= div_dvs;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= CNT_BITS'(SUM_BITS);
        end
        else if (!div_done)
        begin
            dvd_reg <= {dvd_reg[SUM_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg - CNT_BITS'(1);
            if (!trial[SUM_BITS])
            begin
                rem_reg <= trial[SUM_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg  <= job_data;
                    x_reg    <= ext(job_data.a_num);
                    y_reg    <= ext(job_data.a_den);
                    ga_reg   <= ext(job_data.a_num);
                    gb_reg   <= ext(job_data.a_den);
                    rneg_reg <= job_data.a_neg;
                    pass_reg <= PS_FIRST;
                end
            end
            BK_EUCLID:
            begin
                // euclid step: a <- b, b <- a mod b
                if (div_done)
                begin
                    ga_reg <= gb_reg;
                    gb_reg <= rem_reg;
                end
            end
            BK_QUO_X:
            begin
                if (div_done)
                    x_reg <= quo_reg;
            end
            BK_QUO_Y:
            begin
                if (div_done)
                begin
                    case (pass_reg)
                        PS_FIRST:
                        begin
                            if (job_reg.is_reduce)
                                y_reg <= quo_reg;
                            else
                            begin
                                an_reg   <= MAG_BITS'(x_reg);
                                ad_reg   <= MAG_BITS'(quo_reg);
                                x_reg    <= ext(job_reg.b_num);
                                y_reg    <= ext(job_reg.b_den);
                                ga_reg   <= ext(job_reg.b_num);
                                gb_reg   <= ext(job_reg.b_den);
                                pass_reg <= PS_SECOND;
                            end
                        end
                        PS_SECOND:
                        begin
                            bn_reg <= MAG_BITS'(x_reg);
                            bd_reg <= MAG_BITS'(quo_reg);
                        end
                        default:
                            y_reg <= quo_reg;
                    endcase
                end
            end
            BK_MUL:
            begin
                case (job_reg.op)
                    OP_MULTIPLY:
                    begin
                        x_reg    <= m_nn;
                        y_reg    <= m_dd;
                        rneg_reg <= job_reg.a_neg ^ job_reg.b_neg;
                    end
                    OP_DIVIDE:
                    begin
                        x_reg    <= m_nd;
                        y_reg    <= m_dn;
                        rneg_reg <= job_reg.a_neg ^ job_reg.b_neg;
                    end
                    default:
                    begin
                        p1_reg <= m_nd;
                        p2_reg <= m_dn;
                        y_reg  <= m_dd;
                    end
                endcase
            end
            BK_SUM:
            begin
                if (job_reg.op == OP_ADD || job_reg.op == OP_SUBTRACT)
                begin
                    x_reg    <= sum_mag;
                    ga_reg   <= sum_mag;
                    rneg_reg <= sum_neg;
                end
                else
                    ga_reg <= x_reg;
                gb_reg   <= y_reg;
                pass_reg <= PS_RESULT;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (job_reg.status != ST_OK)
                    begin
                        out_reg.result_numerator   <= '0;
                        out_reg.result_denominator <= '0;
                    end
                    else
                    begin
                        out_reg.result_numerator <= rneg_reg
                            ? NUM_OUT_BITS'(SUM_BITS'(0) - x_reg) : NUM_OUT_BITS'(x_reg);
                        out_reg.result_denominator <= DEN_OUT_BITS'(y_reg);
                    end
                    out_reg.status <= job_reg.status;
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the rational arithmetic unit
// drives operations and fraction pairs through the input channel under
// random idling and a long output stall, predicts each reduced fraction and
// status, and compares every output transfer in order against the prediction
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
    } frac_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;

    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_off = 0;
    int         quiet_cycles = 0;

    rational_arithmetic_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic frac_t reduce_frac(input frac_t f);
        logic [63:0] g;
        if (f.num == 0 || f.den == 0)
        begin
            f.neg = 0;
            f.num = 0;
            f.den = 1;
            return f;
        end
        g = gcd64(f.num, f.den);
        f.num = f.num / g;
        f.den = f.den / g;
        return f;
    endfunction

    function automatic frac_t split_frac(input logic signed [15:0] n,
                                         input logic signed [15:0] d);
        frac_t f;
        f.neg = n[15] ^ d[15];
        f.num = n[15] ? -64'(n) : 64'(n);
        f.den = d[15] ? -64'(d) : 64'(d);
        return reduce_frac(f);
    endfunction

    function automatic out_item_t predict_fraction(input in_item_t it);
        out_item_t   r;
        frac_t       a, b, c;
        logic        is_reduce, sb;
        logic [63:0] pa, pb;
        r = '0;
        is_reduce = !(it.operation inside {OP_MULTIPLY, OP_DIVIDE, OP_ADD, OP_SUBTRACT});
        if (it.first_denominator == 0 || (!is_reduce && it.second_denominator == 0))
        begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        if (it.operation == OP_DIVIDE && it.second_numerator == 0)
        begin
            r.status = ST_DIV_ZERO;
            return r;
        end
        a = split_frac(it.first_numerator, it.first_denominator);
        c = a;
        if (!is_reduce)
        begin
            b = split_frac(it.second_numerator, it.second_denominator);
            c.neg = a.neg ^ b.neg;
            c.den = a.den * b.den;
            case (it.operation)
                OP_MULTIPLY: c.num = a.num * b.num;
                OP_DIVIDE:
                begin
                    c.num = a.num * b.den;
                    c.den = a.den * b.num;
                end
                default:
                begin
                    sb = (it.operation == OP_SUBTRACT) ? !b.neg : b.neg;
                    pa = a.num * b.den;
                    pb = b.num * a.den;
                    if (a.neg == sb)
                    begin
                        c.neg = a.neg;
                        c.num = pa + pb;
                    end
                    else if (pa >= pb)
                    begin
                        c.neg = a.neg;
                        c.num = pa - pb;
                    end
                    else
                    begin
                        c.neg = sb;
                        c.num = pb - pa;
                    end
                end
            endcase
            c = reduce_frac(c);
        end
        r.result_numerator = c.neg ? -33'(c.num) : 33'(c.num);
        r.result_denominator = c.den[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    class fraction_scoreboard;
        out_item_t pending[$];

        function void note_input(input in_item_t it);
            pending.push_back(predict_fraction(it));
        endfunction

        task check_result(input out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected transfer", 64'(got.status), 64'(0));
                return;
            end
            want = pending.pop_front();
            if (got.result_numerator !== want.result_numerator)
                report_mismatch("numerator", 64'(signed'(got.result_numerator)),
                                64'(signed'(want.result_numerator)));
            if (got.result_denominator !== want.result_denominator)
                report_mismatch("denominator", 64'(got.result_denominator),
                                64'(want.result_denominator));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

    fraction_scoreboard board = new();

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.note_input(in_data);
            if (out_valid && out_ready)
                board.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(signed'($urandom_range(8)) - 4);
            3: return 16'($urandom_range(48) * (1 << $urandom_range(6)));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        in_item_t it;
        repeat (count)
        begin
            it.operation = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                                   : 3'($urandom_range(4));
            it.first_numerator = pick_value();
            it.first_denominator = pick_value();
            it.second_numerator = pick_value();
            it.second_denominator = pick_value();
            if ($urandom_range(29) == 0)
                it.first_denominator = '0;
            if ($urandom_range(29) == 0)
                it.second_denominator = '0;
            if ($urandom_range(19) == 0)
                it.second_numerator = '0;
            send_item(it);
        end
    endtask

    task automatic send_directed(input logic [2:0] op, input int n1, input int d1,
                                 input int n2, input int d2);
        in_item_t it;
        it.operation = op;
        it.first_numerator = 16'(n1);
        it.first_denominator = 16'(d1);
        it.second_numerator = 16'(n2);
        it.second_denominator = 16'(d2);
        send_item(it);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_directed(OP_REDUCE, 6, -4, 0, 0);
        send_directed(OP_REDUCE, -32768, -32768, 1, 1);
        send_directed(OP_REDUCE, 0, -7, 3, 3);
        send_directed(OP_REDUCE, 5, 0, 1, 1);
        send_directed(OP_MULTIPLY, -32768, 1, -32768, 1);
        send_directed(OP_MULTIPLY, 32767, -32768, 32767, -32768);
        send_directed(OP_MULTIPLY, 3, 4, 0, 1);
        send_directed(OP_MULTIPLY, 3, 4, 1, 0);
        send_directed(OP_DIVIDE, -32768, 1, 1, -32768);
        send_directed(OP_DIVIDE, 1, 32767, -32768, 1);
        send_directed(OP_DIVIDE, 2, 3, 0, 5);
        send_directed(OP_DIVIDE, 2, 0, 0, 5);
        send_directed(OP_ADD, 32767, 32766, 32765, 32764);
        send_directed(OP_ADD, 1, 2, -1, 2);
        send_directed(OP_ADD, -32768, 32767, -32768, 32767);
        send_directed(OP_SUBTRACT, 1, 3, 1, 3);
        send_directed(OP_SUBTRACT, -32768, 32767, 32767, -32768);
        send_directed(OP_SUBTRACT, 1, 2, 3, 4);
        send_directed(3'd5, 12, 18, 0, 0);
        send_directed(3'd6, -9, 3, 1, 0);
        send_directed(3'd7, 4, 0, 1, 1);

        send_idle_pct = 34;
        recv_idle_pct = 48;
        send_random(420);

        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(30);
        join

        send_idle_pct = 48;
        recv_idle_pct = 34;
        send_random(420);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(420);
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
